// ===== hdl/rpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rpe_pkg
// Shared types and constants for the run-length palette pixel expander.
// ----------------------------------------------------------------------------
`default_nettype none

package rpe_pkg;

   localparam int NIBBLE_W    = 4;
   localparam int CODE_W      = 8;
   localparam int COLOR_W     = 16;
   localparam int DIM_W       = 8;
   localparam int SIZE_W      = 2 * DIM_W;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int QUEUE_DEPTH = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_LOW    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_THIRD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_HIGH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT   = 3'd5;

   typedef logic [COLOR_W-1:0] color_type;

   // [quad][entry in quad], matching the packing of the 64-bit palette registers
   typedef color_type [3:0][3:0] palette_type;

   // one classified run waiting for expansion
   typedef struct packed {
      color_type             color;
      logic [NIBBLE_W-1:0]   run_m1;
      logic                  done;
   } job_type;

endpackage

`default_nettype wire

// ===== hdl/rpe_csr.sv =====
// ----------------------------------------------------------------------------
// rpe_csr
// Configuration registers: palette quads and image dimensions, plus image size.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write,
   input  wire logic [rpe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [rpe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output rpe_pkg::palette_type                    palette_o,
   output logic      [rpe_pkg::SIZE_W-1:0]         size_o
);
   import rpe_pkg::*;

   palette_type       palette_ff, palette_in;
   logic [DIM_W-1:0]  width_ff, width_in;
   logic [DIM_W-1:0]  height_ff, height_in;

   always_comb begin
      palette_in = palette_ff;
      width_in   = width_ff;
      height_in  = height_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PALETTE_LOW:    palette_in[0] = csr_wdata;
            CSR_PALETTE_SECOND: palette_in[1] = csr_wdata;
            CSR_PALETTE_THIRD:  palette_in[2] = csr_wdata;
            CSR_PALETTE_HIGH:   palette_in[3] = csr_wdata;
            CSR_IMAGE_WIDTH:    width_in      = csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:   height_in     = csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= '0;
         width_ff   <= DIM_W'(1);
         height_ff  <= DIM_W'(1);
      end else begin
         palette_ff <= palette_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
      end
   end

   assign palette_o = palette_ff;
   assign size_o    = SIZE_W'(width_ff) * SIZE_W'(height_ff);

endmodule

`default_nettype wire

// ===== hdl/rpe_front.sv =====
// ----------------------------------------------------------------------------
// rpe_front
// Accepts coded bytes, looks up the colour and decides whether the run ends
// the image; keeps the pixel count of the current image.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   input  wire logic [rpe_pkg::CODE_W-1:0]    req_coded_byte,
   output logic                               req_full,
   input  wire rpe_pkg::palette_type          palette_i,
   input  wire logic [rpe_pkg::SIZE_W-1:0]    size_i,
   input  wire logic                          job_full_i,
   output logic                               job_push_o,
   output rpe_pkg::job_type                   job_o
);
   import rpe_pkg::*;

   logic [SIZE_W-1:0]   count_ff, count_in;
   logic [SIZE_W:0]     total;
   logic [NIBBLE_W-1:0] pal_idx;
   logic [NIBBLE_W-1:0] run_m1;
   logic                done;

   assign pal_idx = req_coded_byte[CODE_W-1:NIBBLE_W];
   assign run_m1  = req_coded_byte[NIBBLE_W-1:0];

   // run length is run_m1 + 1
   assign total = {1'b0, count_ff} + (SIZE_W+1)'(run_m1) + (SIZE_W+1)'(1);
   assign done  = total >= {1'b0, size_i};

   assign req_full   = job_full_i;
   assign job_push_o = req_push && !job_full_i;

   assign job_o.color  = palette_i[pal_idx[3:2]][pal_idx[1:0]];
   assign job_o.run_m1 = run_m1;
   assign job_o.done   = done;

   always_comb begin
      count_in = count_ff;
      if (job_push_o) begin
         count_in = done ? '0 : total[SIZE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/rpe_fifo.sv =====
// ----------------------------------------------------------------------------
// rpe_fifo
// Short queue of classified runs between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_fifo #(
   parameter int Depth = rpe_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_i,
   input  wire rpe_pkg::job_type  data_i,
   output logic                   full_o,
   input  wire logic              pop_i,
   output rpe_pkg::job_type       data_o,
   output logic                   empty_o
);
   import rpe_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   job_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full_o  = count_ff == CntW'(Depth);
   assign empty_o = count_ff == '0;
   assign do_push = push_i && !full_o;
   assign do_pop  = pop_i && !empty_o;
   assign data_o  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_i;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push_i && full_o))
      else $error("run pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop_i && empty_o))
      else $error("run popped from an empty queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue fill count beyond depth");
`endif

endmodule

`default_nettype wire

// ===== hdl/rpe_back.sv =====
// ----------------------------------------------------------------------------
// rpe_back
// Expands the run at the head of the queue into one pixel per cycle through
// a registered result stage, while that stage is empty or being popped.
// ----------------------------------------------------------------------------
`default_nettype none

module rpe_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          job_empty_i,
   input  wire rpe_pkg::job_type              job_i,
   output logic                               job_pop_o,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [rpe_pkg::COLOR_W-1:0]        rsp_pixel_color,
   output logic                               rsp_run_last,
   output logic                               rsp_image_done
);
   import rpe_pkg::*;

   logic [NIBBLE_W-1:0] idx_ff, idx_in;
   logic                valid_ff, valid_in;
   color_type           color_ff, color_in;
   logic                last_ff, last_in;
   logic                done_ff, done_in;
   logic                out_free;
   logic                emit;
   logic                is_last;

   assign out_free  = !valid_ff || rsp_pop;
   assign emit      = !job_empty_i && out_free;
   assign is_last   = idx_ff == job_i.run_m1;
   assign job_pop_o = emit && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      color_in = color_ff;
      last_in  = last_ff;
      done_in  = done_ff;
      if (emit) begin
         valid_in = 1'b1;
         color_in = job_i.color;
         last_in  = is_last;
         done_in  = is_last && job_i.done;
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      color_ff <= color_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   assign rsp_empty       = !valid_ff;
   assign rsp_pixel_color = color_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_image_done  = done_ff;

`ifndef SYNTHESIS
   // end of image only ever rides on the closing pixel of a run
   a_done_on_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && done_ff |-> last_ff)
      else $error("image done flagged on a pixel that is not the last of its run");
`endif

endmodule

`default_nettype wire

// ===== hdl/rle_palette_pixel_expander.sv =====
// Path: a byte goes into the run queue and its first pixel then into the result
// register; the rest follow one per cycle while each is popped. Throughput: one pixel
// per cycle from the expansion stage while the result stage is free, so a byte coding
// n pixels (1 to 16) holds it for all n; the run queue holds two bytes, the one being
// expanded included. Reset clears the pixel count, the queue and the result stage;
// palette goes to zero and image width and height to one.
// ----------------------------------------------------------------------------
// rle_palette_pixel_expander
// Run-length palette decoder: each coded byte becomes 1 to 16 pixels of one
// 16-bit palette colour, with run and end-of-image flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_palette_pixel_expander #(
   parameter int QueueDepth = rpe_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   input  wire logic [rpe_pkg::CODE_W-1:0]        req_coded_byte,
   output logic                                   req_full,
   output logic                                   rsp_empty,
   input  wire logic                              rsp_pop,
   output logic [rpe_pkg::COLOR_W-1:0]            rsp_pixel_color,
   output logic                                   rsp_run_last,
   output logic                                   rsp_image_done,
   input  wire logic                              csr_write,
   input  wire logic [rpe_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rpe_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import rpe_pkg::*;

   palette_type       palette;
   logic [SIZE_W-1:0] size;
   logic              job_push, job_full, job_pop, job_empty;
   job_type           job_wr, job_rd;

   rpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .palette_o (palette),
      .size_o    (size)
   );

   rpe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_coded_byte (req_coded_byte),
      .req_full       (req_full),
      .palette_i      (palette),
      .size_i         (size),
      .job_full_i     (job_full),
      .job_push_o     (job_push),
      .job_o          (job_wr)
   );

   rpe_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push_i  (job_push),
      .data_i  (job_wr),
      .full_o  (job_full),
      .pop_i   (job_pop),
      .data_o  (job_rd),
      .empty_o (job_empty)
   );

   rpe_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_empty_i     (job_empty),
      .job_i           (job_rd),
      .job_pop_o       (job_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_run_last    (rsp_run_last),
      .rsp_image_done  (rsp_image_done)
   );

endmodule

`default_nettype wire
